// ===== rtl/core/bss_pkg.sv =====
// Shared constants and codes for the bounded stack with sort and search.
`timescale 1ns / 1ps

package bss_pkg;

	// Stack geometry.
	localparam int DEPTH  = 64;
	localparam int WORD_W = 32;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// Operation codes carried on kind.
	localparam logic [2:0] KIND_PUSH    = 3'd0;
	localparam logic [2:0] KIND_POP     = 3'd1;
	localparam logic [2:0] KIND_SORT    = 3'd2;
	localparam logic [2:0] KIND_SEARCH  = 3'd3;
	localparam logic [2:0] KIND_DISPLAY = 3'd4;

	// Result status codes.
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_EMPTY    = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

endpackage

// ===== rtl/core/bss_ram.sv =====
// Simple dual-port RAM: one write port and one read port with registered read data.
`timescale 1ns / 1ps

module bss_ram #(
	parameter int DEPTH  = 64,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/bounded_stack_sort_search_top.sv =====
// Top level of the bounded stack with push, pop, sort, search and display.
`timescale 1ns / 1ps

// A command is transferred at a rising edge where start is high and busy is low;
// kind selects push, pop, sort, search or display and value carries the word to
// push or the search target. Unused kinds are taken and do nothing.
// Every result is a transfer of one cycle, marked by strobe, with status,
// item_value, position, entry_count and last. The receiver cannot stall, so the
// block never waits on the output side. Display produces one result per stored
// entry, bottom first, with last set on the top entry, or a single result on an
// empty stack; push, pop, sort and search each give a single result, last set.
// The entries live in one RAM with one write and one registered read port.
// Push needs no RAM read and pop reads the top entry. Search and display step
// through the stored entries with a read state and then an evaluate state. Sort
// is an exchange sort that holds the current minimum candidate in a register:
// each outer pass loads entry i, compares it with each later entry, and writes
// the settled minimum back to place i. Commands on an empty stack, and sort on
// fewer than two entries, answer from the idle state. Reset empties the stack;
// the RAM is not cleared, since only entries below the fill count are ever used.

module bounded_stack_sort_search_top (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [2:0]               kind,
	input  logic signed [31:0]       value,
	output logic                     strobe,
	output logic [1:0]               status,
	output logic signed [31:0]       item_value,
	output logic [6:0]               position,
	output logic [6:0]               entry_count,
	output logic                     last
);

	// Sequencer state codes.
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_POP   = 4'd1;
	localparam logic [3:0] S_RD_I  = 4'd2;
	localparam logic [3:0] S_LD_I  = 4'd3;
	localparam logic [3:0] S_RD_J  = 4'd4;
	localparam logic [3:0] S_CMP   = 4'd5;
	localparam logic [3:0] S_WR_I  = 4'd6;
	localparam logic [3:0] S_SR_RD = 4'd7;
	localparam logic [3:0] S_SR_EV = 4'd8;
	localparam logic [3:0] S_DS_RD = 4'd9;
	localparam logic [3:0] S_DS_EV = 4'd10;

	logic [3:0]                  state_q;
	logic [bss_pkg::CNT_W-1:0]   fill_q;
	logic [bss_pkg::IDX_W-1:0]   i_q;
	logic [bss_pkg::IDX_W-1:0]   j_q;
	logic [bss_pkg::WORD_W-1:0]  cur_q;
	logic [bss_pkg::WORD_W-1:0]  target_q;
	logic [bss_pkg::CNT_W-1:0]   pos_q;

	logic                        strobe_q;
	logic [1:0]                  status_q;
	logic [bss_pkg::WORD_W-1:0]  item_q;
	logic [bss_pkg::CNT_W-1:0]   position_q;
	logic [bss_pkg::CNT_W-1:0]   count_q;
	logic                        last_q;

	logic                        accept;
	logic                        empty;
	logic                        full;
	logic                        j_is_last;
	logic                        i_is_last;
	logic                        swap;
	logic                        hit;
	logic [bss_pkg::CNT_W-1:0]   j_pos;

	logic                        ram_we;
	logic [bss_pkg::IDX_W-1:0]   ram_waddr;
	logic [bss_pkg::WORD_W-1:0]  ram_wdata;
	logic [bss_pkg::IDX_W-1:0]   ram_raddr;
	logic [bss_pkg::WORD_W-1:0]  ram_rdata;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign empty  = (fill_q == '0);
	assign full   = (fill_q == bss_pkg::CNT_W'(bss_pkg::DEPTH));

	// Position checks against the top of the stack.
	assign j_pos     = {1'b0, j_q} + bss_pkg::CNT_W'(1);
	assign j_is_last = (j_pos == fill_q);
	assign i_is_last = ({1'b0, i_q} + bss_pkg::CNT_W'(2) == fill_q);

	// In the compare step the freshly read entry replaces the held candidate when
	// it is strictly smaller, and the candidate is written to that entry's place.
	assign swap = ($signed(ram_rdata) < $signed(cur_q));
	assign hit  = (ram_rdata == target_q);

	// Read address: the top entry on a pop transfer, otherwise the sweep counters.
	always_comb begin
		if (state_q == S_RD_I) begin
			ram_raddr = i_q;
		end else if (state_q == S_IDLE) begin
			ram_raddr = bss_pkg::IDX_W'(fill_q - bss_pkg::CNT_W'(1));
		end else begin
			ram_raddr = j_q;
		end
	end

	// Write port: push on transfer, swap during the inner pass, and the settled
	// minimum at the end of each outer pass.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = j_q;
		ram_wdata = cur_q;
		if (accept && kind == bss_pkg::KIND_PUSH && !full) begin
			ram_we    = 1'b1;
			ram_waddr = bss_pkg::IDX_W'(fill_q);
			ram_wdata = value;
		end else if (state_q == S_CMP && swap) begin
			ram_we    = 1'b1;
		end else if (state_q == S_WR_I) begin
			ram_we    = 1'b1;
			ram_waddr = i_q;
		end
	end

	bss_ram #(
		.DEPTH (bss_pkg::DEPTH),
		.WIDTH (bss_pkg::WORD_W),
		.ADDR_W(bss_pkg::IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Payload registers of the result port; they need no reset.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				status_q   <= bss_pkg::ST_OK;
				item_q     <= '0;
				position_q <= '0;
				count_q    <= fill_q;
				last_q     <= 1'b1;
				case (kind)
					bss_pkg::KIND_PUSH: begin
						if (full) begin
							status_q <= bss_pkg::ST_FULL;
						end else begin
							count_q <= fill_q + bss_pkg::CNT_W'(1);
						end
					end
					bss_pkg::KIND_POP,
					bss_pkg::KIND_SEARCH,
					bss_pkg::KIND_DISPLAY: begin
						if (empty) begin
							status_q <= bss_pkg::ST_EMPTY;
						end
					end
					default: begin
					end
				endcase
			end
			S_POP: begin
				status_q   <= bss_pkg::ST_OK;
				item_q     <= ram_rdata;
				position_q <= '0;
				count_q    <= fill_q;
				last_q     <= 1'b1;
			end
			S_WR_I: begin
				status_q   <= bss_pkg::ST_OK;
				item_q     <= '0;
				position_q <= '0;
				count_q    <= fill_q;
				last_q     <= 1'b1;
			end
			S_SR_EV: begin
				item_q  <= '0;
				count_q <= fill_q;
				last_q  <= 1'b1;
				if (hit) begin
					status_q   <= bss_pkg::ST_OK;
					position_q <= j_pos;
				end else if (pos_q != '0) begin
					status_q   <= bss_pkg::ST_OK;
					position_q <= pos_q;
				end else begin
					status_q   <= bss_pkg::ST_NOTFOUND;
					position_q <= '0;
				end
			end
			S_DS_EV: begin
				status_q   <= bss_pkg::ST_OK;
				item_q     <= ram_rdata;
				position_q <= '0;
				count_q    <= fill_q;
				last_q     <= j_is_last;
			end
			default: begin
			end
		endcase
	end

	// Sequencer, fill count and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			strobe_q <= 1'b0;
			i_q      <= '0;
			j_q      <= '0;
			cur_q    <= '0;
			target_q <= '0;
			pos_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (kind)
							bss_pkg::KIND_PUSH: begin
								strobe_q <= 1'b1;
								if (!full) begin
									fill_q <= fill_q + bss_pkg::CNT_W'(1);
								end
							end
							bss_pkg::KIND_POP: begin
								if (empty) begin
									strobe_q <= 1'b1;
								end else begin
									fill_q  <= fill_q - bss_pkg::CNT_W'(1);
									state_q <= S_POP;
								end
							end
							bss_pkg::KIND_SORT: begin
								if (fill_q < bss_pkg::CNT_W'(2)) begin
									strobe_q <= 1'b1;
								end else begin
									i_q     <= '0;
									state_q <= S_RD_I;
								end
							end
							bss_pkg::KIND_SEARCH: begin
								if (empty) begin
									strobe_q <= 1'b1;
								end else begin
									j_q      <= '0;
									pos_q    <= '0;
									target_q <= value;
									state_q  <= S_SR_RD;
								end
							end
							bss_pkg::KIND_DISPLAY: begin
								if (empty) begin
									strobe_q <= 1'b1;
								end else begin
									j_q     <= '0;
									state_q <= S_DS_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_POP: begin
					strobe_q <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_RD_I: begin
					state_q <= S_LD_I;
				end
				S_LD_I: begin
					cur_q   <= ram_rdata;
					j_q     <= i_q + bss_pkg::IDX_W'(1);
					state_q <= S_RD_J;
				end
				S_RD_J: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (swap) begin
						cur_q <= ram_rdata;
					end
					if (j_is_last) begin
						state_q <= S_WR_I;
					end else begin
						j_q     <= j_q + bss_pkg::IDX_W'(1);
						state_q <= S_RD_J;
					end
				end
				S_WR_I: begin
					if (i_is_last) begin
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						i_q     <= i_q + bss_pkg::IDX_W'(1);
						state_q <= S_RD_I;
					end
				end
				S_SR_RD: begin
					state_q <= S_SR_EV;
				end
				S_SR_EV: begin
					if (hit) begin
						pos_q <= j_pos;
					end
					if (j_is_last) begin
						strobe_q <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						j_q     <= j_q + bss_pkg::IDX_W'(1);
						state_q <= S_SR_RD;
					end
				end
				S_DS_RD: begin
					state_q <= S_DS_EV;
				end
				S_DS_EV: begin
					strobe_q <= 1'b1;
					if (j_is_last) begin
						state_q <= S_IDLE;
					end else begin
						j_q     <= j_q + bss_pkg::IDX_W'(1);
						state_q <= S_DS_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign strobe      = strobe_q;
	assign status      = status_q;
	assign item_value  = item_q;
	assign position    = position_q;
	assign entry_count = count_q;
	assign last        = last_q;

	// The fill count never passes the stack depth.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= bss_pkg::CNT_W'(bss_pkg::DEPTH))
		else $error("fill count beyond stack depth");

	// While a command is in progress the fill count holds.
	a_fill_stable: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> $stable(fill_q))
		else $error("fill count changed during a command");

	// A result that is not the final one comes from a display still in progress.
	a_more_results: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("non-final result while idle");

	// The sweep index stays within the stored entries.
	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD_J || state_q == S_CMP || state_q == S_SR_RD ||
		 state_q == S_SR_EV || state_q == S_DS_RD || state_q == S_DS_EV)
		|-> ({1'b0, j_q} < fill_q))
		else $error("sweep index past the top of the stack");

	// An empty-stack status always reports zero entries.
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && status == bss_pkg::ST_EMPTY |-> entry_count == '0)
		else $error("empty status with entries present");

endmodule

// ===== verif/tb_bounded_stack_sort_search_top.sv =====
// Self-checking testbench for the bounded stack with push, pop, sort, search and display.
`timescale 1ns / 1ps

module tb_bounded_stack_sort_search_top;

	// The package names only the five real operations. Kinds 5 to 7 are accepted by
	// the block and must leave the stack alone without producing any result.
	localparam logic [2:0] KIND_UNUSED_5 = 3'd5;
	localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
	localparam logic [2:0] KIND_UNUSED_7 = 3'd7;

	// Even if every command were a full-stack sort, the run would stay well below
	// this bound.
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	// This tail outlasts a display of a full stack, so it leaves room for any stray
	// result after the last expected one.
	localparam int TAIL_CYCLES = 4 * bss_pkg::DEPTH + 50;
	localparam int DIRECTED_COUNT = 25;

	// One result as the block presents it on its output ports.
	typedef struct {
		logic [1:0]  status;
		logic [31:0] item_value;
		logic [6:0]  position;
		logic [6:0]  entry_count;
		logic        last;
	} reply_t;

	// One row of the directed table. Where typed is set, the row carries its
	// single result written out by hand; otherwise the predictor supplies it.
	typedef struct packed {
		logic [2:0]  op;
		logic [31:0] word;
		logic        typed;
		logic [1:0]  st;
		logic [31:0] item;
		logic [6:0]  pos;
		logic [6:0]  cnt;
	} stim_row_t;

	// The directed table starts on the empty stack after reset, loads both word
	// extremes, zero, minus one and fifty, and then exercises every operation. It
	// covers the two matches of minus one, a sort, the unused kinds, and pops of
	// the largest entries.
	localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		'{bss_pkg::KIND_POP,     32'd0,         1'b1, bss_pkg::ST_EMPTY, 32'd0, 7'd0, 7'd0},
		'{bss_pkg::KIND_SEARCH,  32'd0,         1'b1, bss_pkg::ST_EMPTY, 32'd0, 7'd0, 7'd0},
		'{bss_pkg::KIND_DISPLAY, 32'd0,         1'b1, bss_pkg::ST_EMPTY, 32'd0, 7'd0, 7'd0},
		'{bss_pkg::KIND_SORT,    32'd0,         1'b1, bss_pkg::ST_OK,    32'd0, 7'd0, 7'd0},
		'{bss_pkg::KIND_PUSH,    32'h7FFF_FFFF, 1'b1, bss_pkg::ST_OK,    32'd0, 7'd0, 7'd1},
		'{bss_pkg::KIND_PUSH,    32'h8000_0000, 1'b1, bss_pkg::ST_OK,    32'd0, 7'd0, 7'd2},
		'{bss_pkg::KIND_PUSH,    32'd0,         1'b1, bss_pkg::ST_OK,    32'd0, 7'd0, 7'd3},
		'{bss_pkg::KIND_PUSH,    32'hFFFF_FFFF, 1'b1, bss_pkg::ST_OK,    32'd0, 7'd0, 7'd4},
		'{bss_pkg::KIND_PUSH,    32'd50,        1'b1, bss_pkg::ST_OK,    32'd0, 7'd0, 7'd5},
		'{bss_pkg::KIND_SEARCH,  32'hFFFF_FFFF, 1'b1, bss_pkg::ST_OK,    32'd0, 7'd4, 7'd5},
		'{bss_pkg::KIND_SEARCH,  32'd12345,     1'b1, bss_pkg::ST_NOTFOUND, 32'd0, 7'd0, 7'd5},
		'{bss_pkg::KIND_PUSH,    32'hFFFF_FFFF, 1'b1, bss_pkg::ST_OK,    32'd0, 7'd0, 7'd6},
		'{bss_pkg::KIND_SEARCH,  32'hFFFF_FFFF, 1'b1, bss_pkg::ST_OK,    32'd0, 7'd6, 7'd6},
		'{bss_pkg::KIND_DISPLAY, 32'hA5A5_5A5A, 1'b0, bss_pkg::ST_OK,    32'd0, 7'd0, 7'd0},
		'{bss_pkg::KIND_SORT,    32'h5A5A_A5A5, 1'b1, bss_pkg::ST_OK,    32'd0, 7'd0, 7'd6},
		'{bss_pkg::KIND_DISPLAY, 32'd0,         1'b0, bss_pkg::ST_OK,    32'd0, 7'd0, 7'd0},
		'{bss_pkg::KIND_SEARCH,  32'hFFFF_FFFF, 1'b0, bss_pkg::ST_OK,    32'd0, 7'd0, 7'd0},
		'{bss_pkg::KIND_SEARCH,  32'h8000_0000, 1'b0, bss_pkg::ST_OK,    32'd0, 7'd0, 7'd0},
		'{KIND_UNUSED_5,         32'd7,         1'b0, bss_pkg::ST_OK,    32'd0, 7'd0, 7'd0},
		'{KIND_UNUSED_6,         32'hFFFF_FFFF, 1'b0, bss_pkg::ST_OK,    32'd0, 7'd0, 7'd0},
		'{KIND_UNUSED_7,         32'h7FFF_FFFF, 1'b0, bss_pkg::ST_OK,    32'd0, 7'd0, 7'd0},
		'{bss_pkg::KIND_POP,     32'd0,         1'b0, bss_pkg::ST_OK,    32'd0, 7'd0, 7'd0},
		'{bss_pkg::KIND_POP,     32'h1234_5678, 1'b0, bss_pkg::ST_OK,    32'd0, 7'd0, 7'd0},
		'{bss_pkg::KIND_SEARCH,  32'd50,        1'b0, bss_pkg::ST_OK,    32'd0, 7'd0, 7'd0},
		'{bss_pkg::KIND_DISPLAY, 32'd0,         1'b0, bss_pkg::ST_OK,    32'd0, 7'd0, 7'd0}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [2:0]         kind = bss_pkg::KIND_PUSH;
	logic signed [31:0] value = '0;
	logic               strobe;
	logic [1:0]         status;
	logic signed [31:0] item_value;
	logic [6:0]         position;
	logic [6:0]         entry_count;
	logic               last;

	// This is the testbench's own image of the stack. It is updated at the edge
	// where each command transfer is accepted.
	logic signed [31:0] model_words [bss_pkg::DEPTH];
	int                 model_fill = 0;

	// Results still owed by the block, oldest first.
	reply_t             pending_replies [$];
	reply_t             no_reply;

	int unsigned        cycle_count = 0;
	int                 mismatch_count = 0;
	int                 results_checked = 0;
	int                 kind_tally [8];
	int                 status_tally [4];
	bit                 quiet_run = 1'b0;

	bounded_stack_sort_search_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.kind        (kind),
		.value       (value),
		.strobe      (strobe),
		.status      (status),
		.item_value  (item_value),
		.position    (position),
		.entry_count (entry_count),
		.last        (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// A hang anywhere in the run, such as busy stuck high or a result that never
	// comes, ends up here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding.",
				cycle_count, pending_replies.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] MISMATCH %s", $realtime, msg);
	endtask

	// Applies one accepted command to the stack image and queues every result
	// that the command must produce, in the order the block must produce them.
	function automatic void predict_stack_op(input logic [2:0] op, input logic [31:0] word);
		reply_t             r;
		logic signed [31:0] swap_word;
		int                 hit;
		r = '{status: bss_pkg::ST_OK, item_value: '0, position: '0, entry_count: '0,
			last: 1'b1};
		hit = 0;
		case (op)
			bss_pkg::KIND_PUSH: begin
				if (model_fill >= bss_pkg::DEPTH) begin
					r.status = bss_pkg::ST_FULL;
				end else begin
					model_words[model_fill] = word;
					model_fill++;
				end
			end
			bss_pkg::KIND_POP: begin
				if (model_fill == 0) begin
					r.status = bss_pkg::ST_EMPTY;
				end else begin
					model_fill--;
					r.item_value = model_words[model_fill];
				end
			end
			bss_pkg::KIND_SORT: begin
				// This is an exchange sort with a signed comparison. Equal words are
				// identical, so the final order is fixed whatever the sort method.
				for (int i = 0; i < model_fill; i++) begin
					for (int j = i + 1; j < model_fill; j++) begin
						if (model_words[j] < model_words[i]) begin
							swap_word = model_words[i];
							model_words[i] = model_words[j];
							model_words[j] = swap_word;
						end
					end
				end
			end
			bss_pkg::KIND_SEARCH: begin
				// A later match overrides an earlier one, so the position reported
				// is that of the match nearest the top.
				for (int i = 0; i < model_fill; i++) begin
					if (model_words[i] == word)
						hit = i + 1;
				end
				if (hit != 0)
					r.position = 7'(hit);
				else if (model_fill == 0)
					r.status = bss_pkg::ST_EMPTY;
				else
					r.status = bss_pkg::ST_NOTFOUND;
			end
			bss_pkg::KIND_DISPLAY: begin
				if (model_fill == 0) begin
					r.status = bss_pkg::ST_EMPTY;
				end else begin
					for (int i = 0; i < model_fill; i++) begin
						r.item_value  = model_words[i];
						r.entry_count = 7'(model_fill);
						r.last        = (i == model_fill - 1);
						pending_replies.push_back(r);
					end
					return;
				end
			end
			default: return;
		endcase
		r.entry_count = 7'(model_fill);
		pending_replies.push_back(r);
	endfunction

	// The draw mixes the two word extremes, a narrow band around zero that makes
	// duplicates and search hits likely, and fully random words.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3: return 32'($urandom_range(0, 15)) - 32'd8;
			default: return $urandom();
		endcase
	endfunction

	// Most search targets are taken from the stack so that searches hit.
	function automatic logic [31:0] search_target();
		if (model_fill > 0 && $urandom_range(0, 9) < 6)
			return model_words[$urandom_range(0, model_fill - 1)];
		return pick_word();
	endfunction

	// The sender idles for a random number of cycles and then presents one
	// command. It holds that command until the transfer is accepted at an edge
	// where busy is low. Start stays high across back-to-back commands, so it is
	// never lowered and raised again in the same time step.
	task automatic issue_command(input logic [2:0] op, input logic [31:0] word,
			input logic typed, input reply_t typed_reply);
		int gap;
		if ($urandom_range(0, 15) == 0)
			quiet_run = !quiet_run;
		gap = quiet_run ? 0 : $urandom_range(0, 19);
		if (gap != 0) begin
			if (start)
				start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		kind  <= op;
		value <= word;
		do @(posedge clk); while (busy !== 1'b0);
		kind_tally[op]++;
		predict_stack_op(op, word);
		// A typed row produces exactly one result, so that result is the one
		// just queued.
		if (typed)
			pending_replies[pending_replies.size() - 1] = typed_reply;
	endtask

	// The sender holds off until the block has delivered everything it owes.
	task automatic drain_replies();
		if (start)
			start <= 1'b0;
		do @(posedge clk); while (pending_replies.size() != 0);
	endtask

	// Random traffic weighted toward push. It also draws a few unused kinds, and
	// these do not count toward the number of items.
	task automatic run_mixed(input int items);
		int         done;
		int         roll;
		logic [2:0] op;
		done = 0;
		while (done < items) begin
			roll = $urandom_range(0, 99);
			if (roll < 38)
				op = bss_pkg::KIND_PUSH;
			else if (roll < 60)
				op = bss_pkg::KIND_POP;
			else if (roll < 70)
				op = bss_pkg::KIND_SORT;
			else if (roll < 85)
				op = bss_pkg::KIND_SEARCH;
			else if (roll < 94)
				op = bss_pkg::KIND_DISPLAY;
			else
				op = 3'($urandom_range(KIND_UNUSED_5, KIND_UNUSED_7));
			if ($urandom_range(0, 11) == 0)
				drain_replies();
			issue_command(op, (op == bss_pkg::KIND_SEARCH) ? search_target() : pick_word(),
				1'b0, no_reply);
			if (op <= bss_pkg::KIND_DISPLAY)
				done++;
		end
	endtask

	// The receiver cannot stall the block. Each strobed result is taken at the
	// edge that closes its cycle and is checked against the oldest expectation,
	// one field at a time.
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && strobe) begin
			if (pending_replies.size() == 0) begin
				report_mismatch($sformatf("result with nothing expected: status %0d item %0d",
					status, item_value));
			end else begin
				want = pending_replies.pop_front();
				results_checked++;
				status_tally[want.status]++;
				if (status !== want.status)
					report_mismatch($sformatf("status got %0d expected %0d",
						status, want.status));
				if (item_value !== want.item_value)
					report_mismatch($sformatf("item_value got %0d expected %0d",
						item_value, $signed(want.item_value)));
				if (position !== want.position)
					report_mismatch($sformatf("position got %0d expected %0d",
						position, want.position));
				if (entry_count !== want.entry_count)
					report_mismatch($sformatf("entry_count got %0d expected %0d",
						entry_count, want.entry_count));
				if (last !== want.last)
					report_mismatch($sformatf("last got %0d expected %0d", last, want.last));
			end
		end
	end

	initial begin
		stim_row_t row;
		reply_t    typed_reply;
		no_reply = '{status: bss_pkg::ST_OK, item_value: '0, position: '0, entry_count: '0,
			last: 1'b1};
		foreach (kind_tally[k])
			kind_tally[k] = 0;
		foreach (status_tally[s])
			status_tally[s] = 0;

		// Reset is asserted once, at time zero, and released on a clock edge.
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: the table is walked in order.
		for (int n = 0; n < DIRECTED_COUNT; n++) begin
			row = DIRECTED_ROWS[n];
			typed_reply = '{status: row.st, item_value: row.item, position: row.pos,
				entry_count: row.cnt, last: 1'b1};
			issue_command(row.op, row.word, row.typed, typed_reply);
		end
		drain_replies();

		// Random part. First comes light mixed traffic, and then a run of pushes
		// fills the stack to the top. Two more pushes must then come back full.
		run_mixed(10);
		drain_replies();
		while (model_fill < bss_pkg::DEPTH)
			issue_command(bss_pkg::KIND_PUSH, pick_word(), 1'b0, no_reply);
		repeat (2) issue_command(bss_pkg::KIND_PUSH, pick_word(), 1'b0, no_reply);

		// On a full stack, display gives the longest burst of results, and sort
		// does the longest walk through the store.
		issue_command(bss_pkg::KIND_DISPLAY, pick_word(), 1'b0, no_reply);
		issue_command(bss_pkg::KIND_SORT, pick_word(), 1'b0, no_reply);
		issue_command(bss_pkg::KIND_SEARCH, search_target(), 1'b0, no_reply);
		issue_command(bss_pkg::KIND_DISPLAY, pick_word(), 1'b0, no_reply);

		// Mixed traffic on the full stack closes the random part.
		run_mixed(25);

		// All command transfers are done. Wait for the results still owed, and then
		// watch a while longer for stray ones.
		start <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_replies.size() != 0)
			report_mismatch($sformatf("%0d expected results never arrived",
				pending_replies.size()));

		$display("Run covered %0d push, %0d pop, %0d sort, %0d search, %0d display, %0d unused.",
			kind_tally[bss_pkg::KIND_PUSH], kind_tally[bss_pkg::KIND_POP],
			kind_tally[bss_pkg::KIND_SORT], kind_tally[bss_pkg::KIND_SEARCH],
			kind_tally[bss_pkg::KIND_DISPLAY],
			kind_tally[KIND_UNUSED_5] + kind_tally[KIND_UNUSED_6] + kind_tally[KIND_UNUSED_7]);
		$display("Checked %0d results: %0d ok, %0d empty, %0d full, %0d not found; %0d mismatches.",
			results_checked, status_tally[bss_pkg::ST_OK], status_tally[bss_pkg::ST_EMPTY],
			status_tally[bss_pkg::ST_FULL], status_tally[bss_pkg::ST_NOTFOUND], mismatch_count);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/bss_pkg.sv
rtl/core/bss_ram.sv
rtl/core/bounded_stack_sort_search_top.sv
verif/tb_bounded_stack_sort_search_top.sv
